// ===== rtl/core/qpt_pkg.sv =====
// Shared types, constants and saturating helpers for the quaternion pose transform.
package qpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 64;
    localparam int LATENCY   = 14;   // start edge to result strobe edge

    localparam logic [W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [W-1:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [W-1:0] QUAT_W_RESET = 64'h0000_0000_0001_0000;

    localparam logic [1:0] RND_ZERO  = 2'd0;
    localparam logic [1:0] RND_NEAR  = 2'd1;
    localparam logic [1:0] RND_FLOOR = 2'd2;

    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_POS_Z  = 3'd2;
    localparam logic [2:0] REG_QUAT_X = 3'd3;
    localparam logic [2:0] REG_QUAT_Y = 3'd4;
    localparam logic [2:0] REG_QUAT_Z = 3'd5;
    localparam logic [2:0] REG_QUAT_W = 3'd6;
    localparam logic [2:0] REG_ROUND  = 3'd7;

    localparam logic ACT_POINT = 1'b0;

    typedef logic [W-1:0] t_word;

    typedef struct packed {
        logic        action;
        logic [63:0] vec_x;
        logic [63:0] vec_y;
        logic [63:0] vec_z;
    } t_in;

    typedef struct packed {
        logic [63:0] res_x;
        logic [63:0] res_y;
        logic [63:0] res_z;
    } t_out;

    function automatic t_word sat_add(input t_word a, input t_word b);
        t_word s;
        s = a + b;
        if (a[W-1] == b[W-1] && s[W-1] != a[W-1]) begin
            s = a[W-1] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        t_word s;
        s = a - b;
        if (a[W-1] != b[W-1] && s[W-1] != a[W-1]) begin
            s = a[W-1] ? SMIN : SMAX;
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/qpt_mul.sv =====
// Four-stage Q48.16 sign-magnitude multiplier with rounding and saturation.
module qpt_mul (
    input  logic              i_clk,
    input  qpt_pkg::t_word    i_a,
    input  qpt_pkg::t_word    i_b,
    input  logic [1:0]        i_rnd,
    output qpt_pkg::t_word    o_p
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg1, r_neg2, r_neg3;
    logic [63:0]  r_p0, r_p1, r_p2, r_p3;
    logic [127:0] r_prod;
    qpt_pkg::t_word r_res;

    logic [128:0] rsum;
    logic [112:0] mag;
    qpt_pkg::t_word n_res;

    always_ff @(posedge i_clk) begin
        r_ua   <= i_a[63] ? (~i_a + 64'd1) : i_a;
        r_ub   <= i_b[63] ? (~i_b + 64'd1) : i_b;
        r_neg1 <= i_a[63] ^ i_b[63];

        r_p0   <= r_ua[31:0]  * r_ub[31:0];
        r_p1   <= r_ua[31:0]  * r_ub[63:32];
        r_p2   <= r_ua[63:32] * r_ub[31:0];
        r_p3   <= r_ua[63:32] * r_ub[63:32];
        r_neg2 <= r_neg1;

        r_prod <= {64'd0, r_p0} + {32'd0, r_p1, 32'd0} + {32'd0, r_p2, 32'd0}
                  + {r_p3, 64'd0};
        r_neg3 <= r_neg2;

        r_res  <= n_res;
    end

    always_comb begin
        rsum = {1'b0, r_prod};
        if (i_rnd == qpt_pkg::RND_NEAR) begin
            rsum = {1'b0, r_prod} + 129'h8000;
        end
        mag = rsum[128:qpt_pkg::FRAC_BITS];
        // floor on a negative product rounds the magnitude up
        if (i_rnd == qpt_pkg::RND_FLOOR && r_neg3
            && r_prod[qpt_pkg::FRAC_BITS-1:0] != '0) begin
            mag = mag + 113'd1;
        end
        if (!r_neg3) begin
            n_res = (mag[112:63] != '0) ? qpt_pkg::SMAX : mag[63:0];
        end else begin
            n_res = (mag[112:63] != '0) ? qpt_pkg::SMIN : (~mag[63:0] + 64'd1);
        end
    end

    assign o_p = r_res;

endmodule

// ===== rtl/core/qpt_cross.sv =====
// Pipelined saturating cross product a x b; the difference of the multiplier outputs is registered.
module qpt_cross (
    input  logic           i_clk,
    input  qpt_pkg::t_word i_a [3],
    input  qpt_pkg::t_word i_b [3],
    input  logic [1:0]     i_rnd,
    output qpt_pkg::t_word o_c [3]
);

    qpt_pkg::t_word pl [3];
    qpt_pkg::t_word pr [3];
    qpt_pkg::t_word r_c [3];

    // component i: a[i+1]*b[i+2] - a[i+2]*b[i+1]
    for (genvar i = 0; i < 3; i++) begin : g_comp
        qpt_mul u_ml (
            .i_clk (i_clk),
            .i_a   (i_a[(i + 1) % 3]),
            .i_b   (i_b[(i + 2) % 3]),
            .i_rnd (i_rnd),
            .o_p   (pl[i])
        );
        qpt_mul u_mr (
            .i_clk (i_clk),
            .i_a   (i_a[(i + 2) % 3]),
            .i_b   (i_b[(i + 1) % 3]),
            .i_rnd (i_rnd),
            .o_p   (pr[i])
        );
        always_ff @(posedge i_clk) begin
            r_c[i] <= qpt_pkg::sat_sub(pl[i], pr[i]);
        end
        assign o_c[i] = r_c[i];
    end

endmodule

// ===== rtl/core/quaternion_pose_transform.sv =====
// Top level of the quaternion pose transform pipeline.
//
//  channel   | direction | handshake              | word
//  ----------+-----------+------------------------+---------------------------
//  command   | in        | i_start / o_busy       | i_in   (t_in)
//  result    | out       | o_res_valid strobe     | o_res  (t_out)
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per cycle; each result strobes after its start has passed the capture stage,
// the two chained four-stage multiplier pipelines and the subtract, double and add stages.
// o_busy is always low and nothing in the pipe ever holds.
// Synchronous active-low reset clears the valid pipe and loads the register reset
// values (identity rotation, zero translation, round toward zero).
module quaternion_pose_transform (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  qpt_pkg::t_in    i_in,
    output logic            o_res_valid,
    output qpt_pkg::t_out   o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data
);

    qpt_pkg::t_word r_pos [3];
    qpt_pkg::t_word r_quat [3];
    qpt_pkg::t_word r_qw;
    logic [1:0]     r_rnd;

    logic [qpt_pkg::LATENCY-1:0] r_vld;

    qpt_pkg::t_word r_v0 [3];
    logic           r_a0;
    qpt_pkg::t_word r_vd [10][3];   // v delayed, stages 1..10
    logic           r_ad [12];      // action delayed, stages 1..12

    qpt_pkg::t_word c1 [3];
    qpt_pkg::t_word r_t [3];
    qpt_pkg::t_word c2 [3];
    qpt_pkg::t_word wt [3];
    qpt_pkg::t_word r_s1 [3];
    qpt_pkg::t_word r_r [3];
    qpt_pkg::t_word r_out [3];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_pos[2]  <= '0;
            r_quat[0] <= '0;
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_qw      <= qpt_pkg::QUAT_W_RESET;
            r_rnd     <= qpt_pkg::RND_ZERO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qpt_pkg::REG_POS_X:  r_pos[0]  <= i_cfg_data;
                qpt_pkg::REG_POS_Y:  r_pos[1]  <= i_cfg_data;
                qpt_pkg::REG_POS_Z:  r_pos[2]  <= i_cfg_data;
                qpt_pkg::REG_QUAT_X: r_quat[0] <= i_cfg_data;
                qpt_pkg::REG_QUAT_Y: r_quat[1] <= i_cfg_data;
                qpt_pkg::REG_QUAT_Z: r_quat[2] <= i_cfg_data;
                qpt_pkg::REG_QUAT_W: r_qw      <= i_cfg_data;
                qpt_pkg::REG_ROUND:  r_rnd     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[qpt_pkg::LATENCY-2:0], i_start};
        end
    end

    // stage 0: capture the command word, and shift the v and action delay lines
    always_ff @(posedge i_clk) begin
        r_v0[0] <= i_in.vec_x;
        r_v0[1] <= i_in.vec_y;
        r_v0[2] <= i_in.vec_z;
        r_a0    <= i_in.action;
        r_vd[0] <= r_v0;
        r_ad[0] <= r_a0;
        for (int k = 1; k < 10; k++) r_vd[k] <= r_vd[k-1];
        for (int k = 1; k < 12; k++) r_ad[k] <= r_ad[k-1];
    end

    // stages 1..5: c1 = q x v
    qpt_cross u_cross1 (
        .i_clk (i_clk),
        .i_a   (r_quat),
        .i_b   (r_v0),
        .i_rnd (r_rnd),
        .o_c   (c1)
    );

    // stages 7..11: c2 = q x t; stages 7..10: w*t
    qpt_cross u_cross2 (
        .i_clk (i_clk),
        .i_a   (r_quat),
        .i_b   (r_t),
        .i_rnd (r_rnd),
        .o_c   (c2)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        qpt_mul u_wt (
            .i_clk (i_clk),
            .i_a   (r_qw),
            .i_b   (r_t[i]),
            .i_rnd (r_rnd),
            .o_p   (wt[i])
        );

        always_ff @(posedge i_clk) begin
            r_t[i]   <= qpt_pkg::sat_add(c1[i], c1[i]);          // stage 6
            r_s1[i]  <= qpt_pkg::sat_add(r_vd[9][i], wt[i]);     // stage 11
            r_r[i]   <= qpt_pkg::sat_add(r_s1[i], c2[i]);        // stage 12
            r_out[i] <= (r_ad[11] == qpt_pkg::ACT_POINT)          // stage 13
                        ? qpt_pkg::sat_add(r_r[i], r_pos[i]) : r_r[i];
        end
    end

    assign o_res_valid = r_vld[qpt_pkg::LATENCY-1];
    assign o_res.res_x = r_out[0];
    assign o_res.res_y = r_out[1];
    assign o_res.res_z = r_out[2];

endmodule

// ===== rtl/core/qpt_checker.sv =====
// Port-level checker for the quaternion pose transform, bound to the top level.
module qpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_res_valid,
    input logic o_cfg_ready
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy && o_cfg_ready)
        else $error("command or config channel refused a word");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(qpt_pkg::LATENCY) o_res_valid)
        else $error("accepted command produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(i_start, qpt_pkg::LATENCY))
        else $error("result strobe without matching command");

endmodule

bind quaternion_pose_transform qpt_checker u_qpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_cfg_ready (o_cfg_ready)
);

// ===== tb/sv/quaternion_pose_transform_tb.sv =====
// Self-checking quaternion pose transform testbench: directed table, pose extremes, then random vectors.
`timescale 1ns / 100ps

module quaternion_pose_transform_tb;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    logic            o_busy;
    qpt_pkg::t_in    i_in = '0;
    logic            o_res_valid;
    qpt_pkg::t_out   o_res;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [2:0]      i_cfg_index = '0;
    logic [63:0]     i_cfg_data = '0;

    quaternion_pose_transform uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the pose registers
    logic [63:0] px, py, pz, qx, qy, qz, qw;
    logic [1:0]  rmode;

    qpt_pkg::t_out expected_q[$];
    int     errors = 0;
    int     idle_cycles = 0;
    localparam int WATCHDOG = 2000;

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic         neg;
        logic [63:0]  ua, ub, rem;
        logic [127:0] p;
        neg = a[63] ^ b[63];
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        rem = {48'd0, p[15:0]};
        if (rmode == qpt_pkg::RND_NEAR) p = p + 128'h8000;
        p = p >> qpt_pkg::FRAC_BITS;
        if (rmode == qpt_pkg::RND_FLOOR && neg && rem != 0) p = p + 1;
        if (!neg) return (p > {64'd0, qpt_pkg::SMAX}) ? qpt_pkg::SMAX : p[63:0];
        if (p >= {64'd0, qpt_pkg::SMIN}) return qpt_pkg::SMIN;
        return -p[63:0];
    endfunction

    function automatic qpt_pkg::t_out rotate_vec(qpt_pkg::t_in v);
        logic [63:0] q[3], a[3], c1[3], t[3], c2[3], p[3], r[3];
        qpt_pkg::t_out o;
        q = '{qx, qy, qz};
        a = '{v.vec_x, v.vec_y, v.vec_z};
        p = '{px, py, pz};
        for (int i = 0; i < 3; i++)
            c1[i] = qpt_pkg::sat_sub(fx_mul(q[(i+1)%3], a[(i+2)%3]),
                                     fx_mul(q[(i+2)%3], a[(i+1)%3]));
        for (int i = 0; i < 3; i++) t[i] = qpt_pkg::sat_add(c1[i], c1[i]);
        for (int i = 0; i < 3; i++)
            c2[i] = qpt_pkg::sat_sub(fx_mul(q[(i+1)%3], t[(i+2)%3]),
                                     fx_mul(q[(i+2)%3], t[(i+1)%3]));
        for (int i = 0; i < 3; i++) begin
            r[i] = qpt_pkg::sat_add(qpt_pkg::sat_add(a[i], fx_mul(qw, t[i])), c2[i]);
            if (v.action == qpt_pkg::ACT_POINT) r[i] = qpt_pkg::sat_add(r[i], p[i]);
        end
        o.res_x = r[0];
        o.res_y = r[1];
        o.res_z = r[2];
        return o;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                errors++;
            end else begin
                qpt_pkg::t_out e;
                e = expected_q.pop_front();
                if (e.res_x !== o_res.res_x) begin
                    $display("%0t: res_x exp %h got %h", $time, e.res_x, o_res.res_x);
                    errors++;
                end
                if (e.res_y !== o_res.res_y) begin
                    $display("%0t: res_y exp %h got %h", $time, e.res_y, o_res.res_y);
                    errors++;
                end
                if (e.res_z !== o_res.res_z) begin
                    $display("%0t: res_z exp %h got %h", $time, e.res_z, o_res.res_z);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with nothing accepted and no result strobe
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    bit calm;

    // leaves i_start high; it drops i_start itself in its random gaps, and the caller drops it before any other pause
    task automatic send_vec(qpt_pkg::t_in v, bit use_fixed = 0,
                            qpt_pkg::t_out fixed = '0);
        if (!calm) begin
            while ($urandom_range(99) < 15) begin
                i_start <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in <= v;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        expected_q.push_back(use_fixed ? fixed : rotate_vec(v));
        @(negedge i_clk);
    endtask

    // leaves i_cfg_valid high; the caller drops it after the last word
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            qpt_pkg::REG_POS_X:  px = val;
            qpt_pkg::REG_POS_Y:  py = val;
            qpt_pkg::REG_POS_Z:  pz = val;
            qpt_pkg::REG_QUAT_X: qx = val;
            qpt_pkg::REG_QUAT_Y: qy = val;
            qpt_pkg::REG_QUAT_Z: qz = val;
            qpt_pkg::REG_QUAT_W: qw = val;
            default:    rmode = (val[1:0] == 2'd3) ? qpt_pkg::RND_ZERO : val[1:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (qpt_pkg::LATENCY + 2) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd_word();
        case ($urandom_range(5))
            0: return qpt_pkg::SMAX;
            1: return qpt_pkg::SMIN;
            2: return {{40{$urandom_range(1) == 1}}, 24'($urandom)};
            3: return {$urandom, $urandom};
            default: return {{44{$urandom_range(1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] rnd_quat();
        // mostly near unit magnitude
        if ($urandom_range(9) == 0) return rnd_word();
        return {{47{$urandom_range(1) == 1}}, 17'($urandom)};
    endfunction

    typedef struct {
        qpt_pkg::t_in  v;
        bit            fixed;
        qpt_pkg::t_out res;
    } t_row;

    t_row table_rows[$];

    initial begin
        qpt_pkg::t_in v;
        px = '0; py = '0; pz = '0; qx = '0; qy = '0; qz = '0;
        qw = qpt_pkg::QUAT_W_RESET; rmode = qpt_pkg::RND_ZERO;
        calm = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity after reset: output equals input
        table_rows.push_back('{'{qpt_pkg::ACT_POINT, 64'h1_0000, -64'sh2_0000, 64'h3}, 1,
                               '{64'h1_0000, -64'sh2_0000, 64'h3}});
        table_rows.push_back('{'{1'b1, qpt_pkg::SMAX, qpt_pkg::SMIN, 64'h0}, 1,
                               '{qpt_pkg::SMAX, qpt_pkg::SMIN, 64'h0}});
        table_rows.push_back('{'{qpt_pkg::ACT_POINT, qpt_pkg::SMIN, qpt_pkg::SMAX, -64'sh1}, 1,
                               '{qpt_pkg::SMIN, qpt_pkg::SMAX, -64'sh1}});
        foreach (table_rows[i])
            send_vec(table_rows[i].v, table_rows[i].fixed, table_rows[i].res);
        drain();

        // extremes of the pose, each rounding mode including code three
        for (int m = 0; m < 4; m++) begin
            write_reg(qpt_pkg::REG_ROUND, 64'(m));
            write_reg(qpt_pkg::REG_QUAT_X, (m == 0) ? qpt_pkg::SMAX : 64'h8000);
            write_reg(qpt_pkg::REG_QUAT_Y, (m == 1) ? qpt_pkg::SMIN : -64'sh5A82);
            write_reg(qpt_pkg::REG_QUAT_Z, 64'h3);
            write_reg(qpt_pkg::REG_QUAT_W, (m == 2) ? qpt_pkg::SMIN : 64'hB505);
            write_reg(qpt_pkg::REG_POS_X, (m == 3) ? qpt_pkg::SMAX : 64'h10_0000);
            write_reg(qpt_pkg::REG_POS_Y, qpt_pkg::SMIN);
            write_reg(qpt_pkg::REG_POS_Z, -64'sh1);
            i_cfg_valid <= 1'b0;
            send_vec('{qpt_pkg::ACT_POINT, qpt_pkg::SMAX, qpt_pkg::SMIN, 64'h1});
            send_vec('{1'b1, -64'sh1, 64'h7FFF, -64'sh8000});
            send_vec('{qpt_pkg::ACT_POINT, 64'h0, 64'h0, 64'h0});
            send_vec('{1'b1, 64'h8000, -64'sh8001, qpt_pkg::SMAX});
            drain();
        end

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(qpt_pkg::REG_POS_X, rnd_word());
            write_reg(qpt_pkg::REG_POS_Y, rnd_word());
            write_reg(qpt_pkg::REG_POS_Z, rnd_word());
            write_reg(qpt_pkg::REG_QUAT_X, rnd_quat());
            write_reg(qpt_pkg::REG_QUAT_Y, rnd_quat());
            write_reg(qpt_pkg::REG_QUAT_Z, rnd_quat());
            write_reg(qpt_pkg::REG_QUAT_W, rnd_quat());
            write_reg(qpt_pkg::REG_ROUND, 64'($urandom_range(3)));
            i_cfg_valid <= 1'b0;
            calm = (ph == 5);
            for (int k = 0; k < 70; k++) begin
                v.action = $urandom_range(1);
                v.vec_x = rnd_word();
                v.vec_y = rnd_word();
                v.vec_z = rnd_word();
                send_vec(v);
                // hold off once until the pipe is empty
                if (ph == 3 && k == 30) begin
                    i_start <= 1'b0;
                    while (expected_q.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
